[rtl/core/wav_riff_header_parser_defines.svh]
// Assertion macros shared by the checker files of the RIFF/WAVE header parser.
// No dependencies; include this file by its bare name.
`ifndef WAV_RIFF_HEADER_PARSER_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRP_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wrp port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WRP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wrp port check failed");

// Next-cycle implication that is also checked across reset.
`define WRP_ASSERT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("wrp port check failed");

`endif

[rtl/core/wrp_pkg.sv]
// Shared types and constants of the RIFF/WAVE header parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wrp_pkg;

    // Chunk tags after upper-case folding, first byte in the top lane.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h464D_5420;
    localparam logic [31:0] TAG_DATA = 32'h4441_5441;

    // Format tags found in the first two bytes of an fmt body.
    localparam logic [15:0] FMT_TAG_PCM = 16'h0001;
    localparam logic [15:0] FMT_TAG_EXT = 16'hFFFE;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_FMT_SHORT  = 3'd2;
    localparam logic [2:0] ST_NO_DATA    = 3'd3;
    localparam logic [2:0] ST_NO_FORMAT  = 3'd4;

    // Format kinds.
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_PCM     = 2'd1;
    localparam logic [1:0] KIND_EXT     = 2'd2;

    // Index of a byte inside an fmt body (the body is at most 40 bytes).
    localparam int IDX_BITS = 6;
    // Only the first 24 body bytes carry fields that are decoded.
    localparam int STAGE_BYTES = 24;
    localparam int STAGE_IDX_BITS = $clog2(STAGE_BYTES);
    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 2;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_file;
    } wrp_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  format_kind;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] frame_bytes;
        logic [15:0] sample_bits;
        logic [15:0] valid_sample_bits;
        logic [31:0] speaker_mask;
        logic [31:0] payload_offset;
        logic [31:0] payload_size;
    } wrp_out_t;

    // One command from the front to the back; several actions may share a beat.
    typedef struct packed {
        logic                clear;   // zero the fmt staging bytes
        logic                wr;      // store one fmt body byte
        logic                decode;  // decode the staged fmt body
        logic                data;    // record a data chunk
        logic                last;    // final byte: produce the result
        logic [2:0]          fail;    // status code from the parse sequencer
        logic [IDX_BITS-1:0] idx;
        logic [7:0]          value;
        logic [31:0]         size;
        logic [31:0]         offset;
    } wrp_cmd_t;

endpackage

[rtl/core/wrp_front.sv]
// Parse sequencer of the RIFF/WAVE header parser: walks the header and chunk
// headers byte by byte and issues commands to the back end. Uses wrp_pkg.
`timescale 1ns / 1ps

module wrp_front
    import wrp_pkg::*;
#(
    parameter int FMT_MAX_BYTES = 40,
    parameter int POSITION_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  wrp_in_t  in_data,
    output logic     in_ready,
    output logic     cmd_valid,
    output wrp_cmd_t cmd,
    input  logic     cmd_ready
);

    localparam int CNT_BITS = $clog2(FMT_MAX_BYTES + 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHUNK  = 3'd1;
    localparam logic [2:0] PH_FMT    = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_HALT   = 3'd4;

    logic [2:0]               phase_reg, phase_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [31:0]              tag_reg, tag_next;
    logic [31:0]              len_reg, len_next;
    logic [32:0]              skip_reg, skip_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     pad_reg, pad_next;
    logic                     bad_reg, bad_next;

    logic                accept;
    logic [7:0]          folded;
    logic [31:0]         tag_shift;
    logic [31:0]         len_lane;
    logic [CNT_BITS-1:0] cnt_inc;
    logic [32:0]         skip_dec;

    // ASCII lower-case letters fold to upper case for tag matching.
    function automatic logic [7:0] fold_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'h20;
        end
        return r;
    endfunction

    assign accept   = in_valid && cmd_ready;
    assign in_ready = cmd_ready;

    // Byte-level helpers for the current beat.
    always_comb begin
        folded    = fold_upper(in_data.byte_in);
        tag_shift = {tag_reg[23:0], folded};
        cnt_inc   = cnt_reg + 1'b1;
        skip_dec  = (skip_reg != 33'd0) ? skip_reg - 33'd1 : skip_reg;
        len_lane  = len_reg;
        case (cnt_reg[1:0])
            2'd0: len_lane[7:0]   = in_data.byte_in;
            2'd1: len_lane[15:8]  = in_data.byte_in;
            2'd2: len_lane[23:16] = in_data.byte_in;
            2'd3: len_lane[31:24] = in_data.byte_in;
            default: len_lane = len_reg;
        endcase
    end

    // Sequencer next state and the command for this beat.
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        skip_next  = skip_reg;
        pos_next   = pos_reg;
        pad_next   = pad_reg;
        bad_next   = bad_reg;
        cmd        = '0;
        cmd_valid  = 1'b0;

        if (accept) begin
            pos_next = pos_reg + 1'b1;
            unique case (phase_reg)
                PH_HEADER: begin
                    tag_next = tag_shift;
                    if (cnt_reg == CNT_BITS'(3) && tag_shift != TAG_RIFF) begin
                        bad_next   = 1'b1;
                        phase_next = PH_HALT;
                    end else if (cnt_reg == CNT_BITS'(11)) begin
                        if (tag_shift != TAG_WAVE) begin
                            bad_next   = 1'b1;
                            phase_next = PH_HALT;
                        end else begin
                            phase_next = PH_CHUNK;
                            cnt_next   = '0;
                        end
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_CHUNK: begin
                    cnt_next = cnt_inc;
                    if (cnt_reg < CNT_BITS'(4)) begin
                        tag_next = tag_shift;
                        if (cnt_reg == '0) begin
                            len_next = '0;
                        end
                    end else begin
                        len_next = len_lane;
                    end
                    // Eighth header byte: the chunk length is complete.
                    if (cnt_reg == CNT_BITS'(7)) begin
                        cnt_next = '0;
                        pad_next = len_lane[0];
                        if (tag_reg == TAG_FMT && len_lane <= 32'(FMT_MAX_BYTES)) begin
                            skip_next = '0;
                            if (len_lane == 32'd0) begin
                                phase_next = PH_CHUNK;
                            end else begin
                                phase_next = PH_FMT;
                                cmd.clear  = 1'b1;
                            end
                        end else begin
                            if (tag_reg == TAG_DATA) begin
                                cmd.data   = 1'b1;
                                cmd.size   = len_lane;
                                cmd.offset = 32'(pos_next);
                            end
                            skip_next  = {1'b0, len_lane} + 33'(len_lane[0]);
                            phase_next = (len_lane == 32'd0) ? PH_CHUNK : PH_SKIP;
                        end
                    end
                end
                PH_FMT: begin
                    cmd.wr    = 1'b1;
                    cmd.idx   = IDX_BITS'(cnt_reg);
                    cmd.value = in_data.byte_in;
                    cnt_next  = cnt_inc;
                    if (32'(cnt_inc) >= len_reg) begin
                        cmd.decode = 1'b1;
                        cnt_next   = '0;
                        skip_next  = 33'(pad_reg);
                        phase_next = pad_reg ? PH_SKIP : PH_CHUNK;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 33'd0) begin
                        phase_next = PH_CHUNK;
                        cnt_next   = '0;
                    end
                end
                PH_HALT: begin
                    phase_next = PH_HALT;
                end
                default: begin
                    phase_next = PH_HALT;
                end
            endcase

            // Final byte: settle the sequencer's status and start over.
            if (in_data.end_of_file) begin
                cmd.last = 1'b1;
                if (phase_next == PH_HEADER || bad_next) begin
                    cmd.fail = ST_BAD_HEADER;
                end else if (phase_next == PH_FMT) begin
                    cmd.fail = ST_FMT_SHORT;
                end else begin
                    cmd.fail = ST_OK;
                end
                phase_next = PH_HEADER;
                cnt_next   = '0;
                tag_next   = '0;
                len_next   = '0;
                skip_next  = '0;
                pos_next   = '0;
                pad_next   = 1'b0;
                bad_next   = 1'b0;
            end

            cmd_valid = cmd.clear || cmd.wr || cmd.decode || cmd.data || cmd.last;
        end
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            tag_reg   <= '0;
            len_reg   <= '0;
            skip_reg  <= '0;
            pos_reg   <= '0;
            pad_reg   <= 1'b0;
            bad_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            pad_reg   <= pad_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

[rtl/core/wrp_cmd_fifo.sv]
// Short command queue between the parse sequencer and the back end.
// Uses wrp_pkg for the command type and the queue depth.
`timescale 1ns / 1ps

module wrp_cmd_fifo
    import wrp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    input  wrp_cmd_t push_data,
    output logic     push_ready,
    output logic     pop_valid,
    output wrp_cmd_t pop_data,
    input  logic     pop_ready
);

    localparam int PTR_BITS = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(CMD_DEPTH + 1);

    wrp_cmd_t            mem_reg [CMD_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_BITS'(CMD_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/wrp_back.sv]
// Back end of the RIFF/WAVE header parser: stages fmt bytes, commits decoded
// formats and data chunk records, and builds the result beat. Uses wrp_pkg.
`timescale 1ns / 1ps

module wrp_back
    import wrp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cmd_valid,
    input  wrp_cmd_t cmd,
    output logic     cmd_ready,
    output logic     out_valid,
    output wrp_out_t out_data,
    input  logic     out_ready
);

    typedef struct packed {
        logic [15:0] channels;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [15:0] align;
        logic [15:0] bits;
        logic [15:0] valid;
        logic [31:0] mask;
    } wrp_fmt_t;

    logic [7:0]  stage_reg [STAGE_BYTES];
    logic [7:0]  stage_next [STAGE_BYTES];
    wrp_fmt_t    fmt_reg, fmt_next;
    logic [1:0]  kind_reg, kind_upd, kind_next;
    logic [31:0] dsize_reg, dsize_upd, dsize_next;
    logic [31:0] doff_reg, doff_next;
    logic        out_valid_reg, out_valid_next;
    wrp_out_t    out_data_reg, out_data_next;

    logic        take;
    logic [15:0] fmt_tag;
    logic [2:0]  status;

    // A final beat waits until the output register is free.
    assign cmd_ready = !cmd.last || !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Staging bytes: cleared at an fmt chunk start, written one body byte a beat.
    always_comb begin
        stage_next = stage_reg;
        if (take && cmd.clear) begin
            for (int i = 0; i < STAGE_BYTES; i++) begin
                stage_next[i] = 8'h00;
            end
        end
        if (take && cmd.wr && cmd.idx < IDX_BITS'(STAGE_BYTES)) begin
            stage_next[cmd.idx[STAGE_IDX_BITS-1:0]] = cmd.value;
        end
    end

    assign fmt_tag = {stage_next[1], stage_next[0]};

    // Format decode and data chunk record.
    always_comb begin
        fmt_next  = fmt_reg;
        kind_upd  = kind_reg;
        dsize_upd = dsize_reg;
        doff_next = doff_reg;
        if (take && cmd.decode && (fmt_tag == FMT_TAG_PCM || fmt_tag == FMT_TAG_EXT)) begin
            fmt_next.channels = {stage_next[3], stage_next[2]};
            fmt_next.rate     = {stage_next[7], stage_next[6], stage_next[5], stage_next[4]};
            fmt_next.brate    = {stage_next[11], stage_next[10], stage_next[9], stage_next[8]};
            fmt_next.align    = {stage_next[13], stage_next[12]};
            fmt_next.bits     = {stage_next[15], stage_next[14]};
            if (fmt_tag == FMT_TAG_PCM) begin
                kind_upd = KIND_PCM;
            end else begin
                kind_upd       = KIND_EXT;
                fmt_next.valid = {stage_next[19], stage_next[18]};
                fmt_next.mask  = {stage_next[23], stage_next[22], stage_next[21],
                                  stage_next[20]};
            end
        end
        if (take && cmd.data) begin
            dsize_upd = cmd.size;
            doff_next = cmd.offset;
        end
    end

    // Result beat, and return to the reset record after the final byte.
    always_comb begin
        if (cmd.fail != ST_OK) begin
            status = cmd.fail;
        end else if (dsize_upd == 32'd0) begin
            status = ST_NO_DATA;
        end else if (kind_upd == KIND_UNKNOWN) begin
            status = ST_NO_FORMAT;
        end else begin
            status = ST_OK;
        end

        out_data_next        = '0;
        out_data_next.status = status;
        if (status == ST_OK) begin
            out_data_next.format_kind    = kind_upd;
            out_data_next.channel_count  = fmt_next.channels;
            out_data_next.sample_rate    = fmt_next.rate;
            out_data_next.byte_rate      = fmt_next.brate;
            out_data_next.frame_bytes    = fmt_next.align;
            out_data_next.sample_bits    = fmt_next.bits;
            out_data_next.payload_offset = doff_next;
            out_data_next.payload_size   = dsize_upd;
            if (kind_upd == KIND_EXT) begin
                out_data_next.valid_sample_bits = fmt_next.valid;
                out_data_next.speaker_mask      = fmt_next.mask;
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_upd;
        dsize_next     = dsize_upd;
        if (take && cmd.last) begin
            out_valid_next = 1'b1;
            kind_next      = KIND_UNKNOWN;
            dsize_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= KIND_UNKNOWN;
            dsize_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            kind_reg      <= kind_next;
            dsize_reg     <= dsize_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
        fmt_reg   <= fmt_next;
        doff_reg  <= doff_next;
        if (take && cmd.last) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[rtl/core/wav_riff_header_parser.sv]
// RIFF/WAVE header parser.
// The input channel (s_valid, s_ready, s_data) carries one file byte per beat;
// s_data.end_of_file marks the final byte of the stream. The result channel
// (m_valid, m_ready, m_data) carries one beat per stream, after its final byte:
// status, format fields and the offset and size of the data chunk body.
// The block accepts one byte per cycle while the command queue has room.
// The parse sequencer turns each byte into at most one queued command, and the
// back end applies one command per cycle except while a final command waits.
// The two-entry command queue lets bytes keep flowing while the back end or
// the receiver stalls; s_ready drops only once the queue is full, which
// happens when a finished result waits in the output register and another
// final byte reaches the back end.
// Reset (aresetn low, synchronous) returns the sequencer to the start of a
// header, empties the queue and drops m_valid. After each final byte the
// parser starts over on a fresh stream by itself.
// Depends on wrp_pkg, wrp_front, wrp_cmd_fifo and wrp_back.
`timescale 1ns / 1ps

module wav_riff_header_parser
    import wrp_pkg::*;
#(
    parameter int FMT_MAX_BYTES = 40,
    parameter int POSITION_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  wrp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output wrp_out_t m_data
);

    logic     push_valid, push_ready;
    wrp_cmd_t push_cmd;
    logic     pop_valid, pop_ready;
    wrp_cmd_t pop_cmd;

    // Parse sequencer.
    wrp_front #(
        .FMT_MAX_BYTES (FMT_MAX_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .in_ready  (s_ready),
        .cmd_valid (push_valid),
        .cmd       (push_cmd),
        .cmd_ready (push_ready)
    );

    // Command queue.
    wrp_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_cmd),
        .pop_ready  (pop_ready)
    );

    // Format store and result builder.
    wrp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_ready (pop_ready),
        .out_valid (m_valid),
        .out_data  (m_data),
        .out_ready (m_ready)
    );

endmodule

[rtl/core/wrp_port_checker.sv]
// Port-level checks of the RIFF/WAVE header parser, bound to its top level.
// Uses wrp_pkg and the macros of wav_riff_header_parser_defines.svh.
`timescale 1ns / 1ps
`include "wav_riff_header_parser_defines.svh"

module wrp_port_checker
    import wrp_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input wrp_out_t m_data
);

    logic fail_fields_zero;
    logic ok_fields_set;
    logic ext_fields_zero;

    // Field summaries used by the result checks below.
    assign fail_fields_zero = (m_data.format_kind == KIND_UNKNOWN)
                              && (m_data.payload_size == 32'd0)
                              && (m_data.sample_rate == 32'd0);
    assign ok_fields_set    = (m_data.format_kind != KIND_UNKNOWN)
                              && (m_data.payload_size != 32'd0);
    assign ext_fields_zero  = (m_data.valid_sample_bits == 16'd0)
                              && (m_data.speaker_mask == 32'd0);

    // No result beat directly after a reset cycle.
    `WRP_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid)

    // A stalled result beat holds.
    `WRP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // A failed parse reports no format and no data fields.
    `WRP_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_valid && m_data.status != ST_OK, fail_fields_zero)

    // Success needs a known format and a non-empty data chunk.
    `WRP_ASSERT_IMPL(a_ok_fields, aclk, aresetn, m_valid && m_data.status == ST_OK, ok_fields_set)

    // Extensible-only fields stay zero for any other format kind.
    `WRP_ASSERT_IMPL(a_ext_only, aclk, aresetn, m_valid && m_data.format_kind != KIND_EXT, ext_fields_zero)

endmodule

bind wav_riff_header_parser wrp_port_checker u_port_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/wrp_report_checker.sv]
// Result checker for the RIFF/WAVE header parser testbench.
// Depends on wrp_pkg. Predicts each result beat from the accepted input beats and compares it.
`timescale 1ns / 1ps

module wrp_report_checker
    import wrp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  wrp_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  wrp_out_t m_data,
    output int       mismatches,
    output int       outstanding
);

    localparam int FMT_LIMIT = 40;

    typedef enum logic [2:0] {
        P_HEADER,
        P_CHUNK,
        P_FMT,
        P_SKIP,
        P_HALT
    } parse_phase_e;

    // Shadow copy of the parser state.
    parse_phase_e phase;
    int unsigned  hdr_count;
    logic [31:0]  tag_shift;
    logic [31:0]  chunk_len;
    logic [32:0]  bytes_to_skip;
    logic [31:0]  stream_pos;
    logic [7:0]   fmt_body [FMT_LIMIT];
    logic         pad_byte;
    logic [2:0]   fail_status;
    logic [1:0]   fmt_kind;
    logic [15:0]  f_channels, f_align, f_bits, f_valid;
    logic [31:0]  f_rate, f_byte_rate, f_mask;
    logic [31:0]  data_off, data_len;

    // Result beats predicted but not yet seen on the output.
    wrp_out_t expected_reports[$];

    task automatic clear_parse_state();
        phase = P_HEADER;
        hdr_count = 0;
        tag_shift = '0;
        chunk_len = '0;
        bytes_to_skip = '0;
        stream_pos = '0;
        foreach (fmt_body[i]) fmt_body[i] = '0;
        pad_byte = 1'b0;
        fail_status = ST_OK;
        fmt_kind = KIND_UNKNOWN;
        f_channels = '0;
        f_align = '0;
        f_bits = '0;
        f_valid = '0;
        f_rate = '0;
        f_byte_rate = '0;
        f_mask = '0;
        data_off = '0;
        data_len = '0;
    endtask

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // Latch the format fields when the buffered fmt body carries a known tag.
    task automatic commit_fmt();
        logic [15:0] code;
        code = {fmt_body[1], fmt_body[0]};
        if (code == FMT_TAG_PCM || code == FMT_TAG_EXT) begin
            f_channels  = {fmt_body[3], fmt_body[2]};
            f_rate      = {fmt_body[7], fmt_body[6], fmt_body[5], fmt_body[4]};
            f_byte_rate = {fmt_body[11], fmt_body[10], fmt_body[9], fmt_body[8]};
            f_align     = {fmt_body[13], fmt_body[12]};
            f_bits      = {fmt_body[15], fmt_body[14]};
            if (code == FMT_TAG_PCM) begin
                fmt_kind = KIND_PCM;
            end else begin
                fmt_kind = KIND_EXT;
                f_valid  = {fmt_body[19], fmt_body[18]};
                f_mask   = {fmt_body[23], fmt_body[22], fmt_body[21], fmt_body[20]};
            end
        end
    endtask

    task automatic begin_skip(logic [32:0] n);
        bytes_to_skip = n;
        hdr_count = 0;
        phase = (n == 0) ? P_CHUNK : P_SKIP;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        wrp_out_t predicted;
        wrp_out_t seen;
        if (!aresetn) begin
            clear_parse_state();
            expected_reports.delete();
        end else begin
            // Advance the shadow parser by one accepted input beat.
            if (s_valid && s_ready) begin
                stream_pos = stream_pos + 32'd1;
                case (phase)
                    P_HEADER: begin
                        tag_shift = {tag_shift[23:0], to_upper(s_data.byte_in)};
                        if (hdr_count == 3 && tag_shift != TAG_RIFF) begin
                            fail_status = ST_BAD_HEADER;
                            phase = P_HALT;
                        end else if (hdr_count == 11) begin
                            if (tag_shift != TAG_WAVE) begin
                                fail_status = ST_BAD_HEADER;
                                phase = P_HALT;
                            end else begin
                                phase = P_CHUNK;
                                hdr_count = 0;
                            end
                        end else begin
                            hdr_count++;
                        end
                    end
                    P_CHUNK: begin
                        if (hdr_count < 4) begin
                            tag_shift = {tag_shift[23:0], to_upper(s_data.byte_in)};
                            if (hdr_count == 0) chunk_len = '0;
                        end else begin
                            chunk_len = chunk_len
                                      | (32'(s_data.byte_in) << (8 * ((hdr_count - 4) & 3)));
                        end
                        hdr_count++;
                        // A complete chunk header either opens an fmt body or a skip.
                        if (hdr_count >= 8) begin
                            pad_byte = chunk_len[0];
                            if (tag_shift == TAG_FMT && chunk_len <= FMT_LIMIT) begin
                                foreach (fmt_body[i]) fmt_body[i] = '0;
                                hdr_count = 0;
                                if (chunk_len == 0) begin
                                    commit_fmt();
                                    begin_skip('0);
                                end else begin
                                    phase = P_FMT;
                                end
                            end else begin
                                if (tag_shift == TAG_DATA) begin
                                    data_len = chunk_len;
                                    data_off = stream_pos;
                                end
                                begin_skip({1'b0, chunk_len} + 33'(pad_byte));
                            end
                        end
                    end
                    P_FMT: begin
                        if (hdr_count < FMT_LIMIT) fmt_body[hdr_count] = s_data.byte_in;
                        hdr_count++;
                        if (hdr_count >= chunk_len) begin
                            commit_fmt();
                            begin_skip(33'(pad_byte));
                        end
                    end
                    P_SKIP: begin
                        if (bytes_to_skip > 0) bytes_to_skip--;
                        if (bytes_to_skip == 0) begin
                            phase = P_CHUNK;
                            hdr_count = 0;
                        end
                    end
                    default: ;
                endcase

                // The final byte of a stream produces one result and restarts the parser.
                if (s_data.end_of_file) begin
                    if (phase == P_HEADER) fail_status = ST_BAD_HEADER;
                    else if (phase == P_FMT) fail_status = ST_FMT_SHORT;
                    predicted = '0;
                    if (fail_status != ST_OK) begin
                        predicted.status = fail_status;
                    end else if (data_len == 0) begin
                        predicted.status = ST_NO_DATA;
                    end else if (fmt_kind == KIND_UNKNOWN) begin
                        predicted.status = ST_NO_FORMAT;
                    end else begin
                        predicted.status         = ST_OK;
                        predicted.format_kind    = fmt_kind;
                        predicted.channel_count  = f_channels;
                        predicted.sample_rate    = f_rate;
                        predicted.byte_rate      = f_byte_rate;
                        predicted.frame_bytes    = f_align;
                        predicted.sample_bits    = f_bits;
                        predicted.payload_offset = data_off;
                        predicted.payload_size   = data_len;
                        if (fmt_kind == KIND_EXT) begin
                            predicted.valid_sample_bits = f_valid;
                            predicted.speaker_mask      = f_mask;
                        end
                    end
                    expected_reports.push_back(predicted);
                    clear_parse_state();
                end
            end

            // Compare each result beat with the oldest prediction.
            if (m_valid && m_ready) begin
                seen = m_data;
                if (expected_reports.size() == 0) begin
                    $error("result beat with no stream awaiting a result");
                    mismatches++;
                end else begin
                    predicted = expected_reports.pop_front();
                    check_field("status", predicted.status, seen.status);
                    check_field("format_kind", predicted.format_kind, seen.format_kind);
                    check_field("channel_count", predicted.channel_count, seen.channel_count);
                    check_field("sample_rate", predicted.sample_rate, seen.sample_rate);
                    check_field("byte_rate", predicted.byte_rate, seen.byte_rate);
                    check_field("frame_bytes", predicted.frame_bytes, seen.frame_bytes);
                    check_field("sample_bits", predicted.sample_bits, seen.sample_bits);
                    check_field("valid_sample_bits", predicted.valid_sample_bits,
                                seen.valid_sample_bits);
                    check_field("speaker_mask", predicted.speaker_mask, seen.speaker_mask);
                    check_field("payload_offset", predicted.payload_offset,
                                seen.payload_offset);
                    check_field("payload_size", predicted.payload_size, seen.payload_size);
                end
            end
        end
        outstanding = expected_reports.size();
    end

endmodule

[verif/tb_wav_riff_header_parser.sv]
// Top of the RIFF/WAVE header parser testbench: clock, reset, byte streams and verdict.
// Depends on wrp_pkg, wav_riff_header_parser and wrp_report_checker.
`timescale 1ns / 1ps

module tb_wav_riff_header_parser
    import wrp_pkg::*;
();

    localparam int          ITEM_TARGET  = 1250;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam logic [31:0] TAG_LIST     = 32'h4C49_5354;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    wrp_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    wrp_out_t m_data;

    int mismatches;
    int outstanding;

    int          bytes_sent = 0;
    int unsigned cycle_count = 0;
    bit          quiet_phase = 1'b0;
    bit          hold_request = 1'b0;
    bit          idle_sender = 1'b1;
    logic [7:0]  stream_bytes[$];

    // Receiver pacing state.
    int unsigned ready_gap = 0;
    int unsigned mode_left = 0;
    bit          ready_idles = 1'b0;
    bit          long_hold_done = 1'b0;

    always #4 aclk = ~aclk;

    wav_riff_header_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    wrp_report_checker report_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure bursts, one long hold-off on request.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            mode_left = $urandom_range(50, 300);
            ready_idles = ($urandom_range(0, 2) != 0);
        end else begin
            mode_left--;
        end
        if (ready_gap > 0) begin
            ready_gap--;
            m_ready <= 1'b0;
        end else if (hold_request && !long_hold_done) begin
            long_hold_done = 1'b1;
            ready_gap = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (ready_idles && !quiet_phase && $urandom_range(0, 7) == 0) begin
            ready_gap = $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Tag bytes, first byte first, with random lower-casing of letters.
    function automatic void push_tag(logic [31:0] tag);
        logic [7:0] c;
        for (int k = 3; k >= 0; k--) begin
            c = tag[8*k +: 8];
            if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) c = c | 8'h20;
            stream_bytes.push_back(c);
        end
    endfunction

    function automatic void push_word(logic [31:0] w);
        for (int k = 0; k < 4; k++) stream_bytes.push_back(w[8*k +: 8]);
    endfunction

    // Chunk body: a two-byte code up front, random filler, pad byte after an odd length.
    function automatic void push_body(int len, logic [15:0] code);
        for (int k = 0; k < len; k++) begin
            if (k < 2) stream_bytes.push_back(code[8*k +: 8]);
            else stream_bytes.push_back(8'($urandom));
        end
        if (len % 2 == 1) stream_bytes.push_back(8'($urandom));
    endfunction

    // A well-formed file start followed by a random chunk sequence, sometimes cut short.
    function automatic void build_wave_stream();
        int          chunks;
        int          pick;
        int          kind_sel;
        int          len;
        int          cut;
        logic [15:0] code;
        bit          stream_open;
        push_tag(TAG_RIFF);
        push_word($urandom);
        push_tag(TAG_WAVE);
        chunks = $urandom_range(0, 4);
        stream_open = 1'b1;
        for (int c = 0; c < chunks && stream_open; c++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                // fmt chunk: PCM, extensible, unknown tag, empty, or too long to buffer.
                kind_sel = $urandom_range(0, 7);
                if (kind_sel < 3 || kind_sel == 7) code = FMT_TAG_PCM;
                else if (kind_sel < 5) code = FMT_TAG_EXT;
                else code = 16'($urandom);
                case (kind_sel) inside
                    [0:2]:   len = ($urandom_range(0, 1) == 1) ? 16 : $urandom_range(14, 40);
                    [3:4]:   len = ($urandom_range(0, 2) != 0) ? 40 : $urandom_range(2, 40);
                    5:       len = $urandom_range(2, 40);
                    6:       len = 0;
                    default: len = $urandom_range(41, 47);
                endcase
                push_tag(TAG_FMT);
                push_word(len);
                push_body(len, code);
            end else if (pick < 6) begin
                len = $urandom_range(0, 9);
                push_tag(TAG_DATA);
                push_word(len);
                push_body(len, 16'($urandom));
            end else if (pick == 6) begin
                // Large data chunk: the stream ends inside its body.
                push_tag(TAG_DATA);
                push_word($urandom);
                repeat ($urandom_range(0, 5)) stream_bytes.push_back(8'($urandom));
                stream_open = 1'b0;
            end else begin
                len = $urandom_range(0, 9);
                push_tag((pick == 9) ? 32'($urandom) : TAG_LIST);
                push_word(len);
                push_body(len, 16'($urandom));
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
        end
    endfunction

    function automatic void build_noise_stream(int max_len);
        if ($urandom_range(0, 1) == 1) push_tag(TAG_RIFF);
        repeat ($urandom_range(1, max_len)) stream_bytes.push_back(8'($urandom));
    endfunction

    // Offer the queued stream one beat at a time; the final beat carries end_of_file.
    task automatic send_stream();
        wrp_in_t beat;
        foreach (stream_bytes[i]) begin
            if (!quiet_phase && !hold_request && idle_sender
                && $urandom_range(0, 7) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            beat.byte_in = stream_bytes[i];
            beat.end_of_file = (i == stream_bytes.size() - 1);
            s_valid <= 1'b1;
            s_data <= beat;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            bytes_sent++;
        end
        stream_bytes.delete();
        idle_sender = ($urandom_range(0, 3) != 0);
    endtask

    initial begin : stimulus
        int pick;
        int flip_at;
        bit pressure_done;
        pressure_done = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a lone byte, lower-case header with all-ones size,
        // a bad first tag, and a stream that ends inside the header.
        stream_bytes = {8'h00};
        send_stream();
        stream_bytes = {8'h72, 8'h69, 8'h66, 8'h66, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        8'h77, 8'h61, 8'h76, 8'h65};
        send_stream();
        stream_bytes = {8'h52, 8'h49, 8'h46, 8'hFF};
        send_stream();
        stream_bytes = {8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00};
        send_stream();

        // Random streams: mostly well-formed files, some corrupted headers and noise.
        while (bytes_sent < ITEM_TARGET) begin
            if (!pressure_done && bytes_sent >= ITEM_TARGET / 3) begin
                // Hold the result side off while short streams keep arriving.
                pressure_done = 1'b1;
                hold_request = 1'b1;
                repeat (8) begin
                    build_noise_stream(3);
                    send_stream();
                end
                hold_request = 1'b0;
            end
            if (bytes_sent >= ITEM_TARGET * 4 / 5) quiet_phase = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                build_wave_stream();
            end else if (pick < 17) begin
                build_wave_stream();
                flip_at = $urandom_range(0, (stream_bytes.size() < 12)
                                            ? stream_bytes.size() - 1 : 11);
                stream_bytes[flip_at] = stream_bytes[flip_at] ^ (8'h01 << $urandom_range(0, 7));
            end else begin
                build_noise_stream(20);
            end
            send_stream();
        end
        s_valid <= 1'b0;

        // Let the outstanding results drain, then give the verdict.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
